@@ rtl/dacs_pkg.sv @@
// Shared constants and types for the decimal accumulator step machine.
`timescale 1ns / 1ps
package dacs_pkg;
   localparam int MEM_DEPTH  = 1000;
   localparam int NUM_REGS   = 4;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = 10;
   localparam int REG_W      = 2;
   localparam int FLAG_W     = 6;

   // reciprocal constants for the digit split: x/1000 = (x*M)>>38 over 32-bit x,
   // q/10 = (q*M)>>35; quotient widths cover the largest positive word
   localparam logic [31:0] DIV1000_MAGIC = 32'h1062_4DD3;
   localparam int          DIV1000_SHIFT = 38;
   localparam logic [31:0] DIV10_MAGIC   = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT   = 35;
   localparam int          Q1_W          = 22;
   localparam int          OPQ_W         = 18;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_LOAD    = 2'd0;
   localparam cmd_type CMD_RESTART = 2'd1;
   localparam cmd_type CMD_STEP    = 2'd2;
   localparam cmd_type CMD_NOP     = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_DONE   = 2'd1;
   localparam status_type ST_DIVZ   = 2'd2;
   localparam status_type ST_BADIDX = 2'd3;

   typedef logic [3:0] op_type;
   localparam op_type OP_ADD = 4'd1;
   localparam op_type OP_SUB = 4'd2;
   localparam op_type OP_MUL = 4'd3;
   localparam op_type OP_LD  = 4'd4;
   localparam op_type OP_ST  = 4'd5;
   localparam op_type OP_CMP = 4'd6;
   localparam op_type OP_BR  = 4'd7;
   localparam op_type OP_DIV = 4'd8;
   localparam op_type OP_RD  = 4'd9;
   localparam op_type OP_DSP = 4'd10;
endpackage

@@ rtl/decimal_accumulator_cpu_step.sv @@
// Top level: decimal-encoded accumulator machine, one command per beat.
`timescale 1ns / 1ps
// One command per request beat, one response beat each. Load, restart, the unused
// command and a step past the end go straight to the response. A step reads the
// instruction word and splits it into opcode, register and address digits with
// two reciprocal multiplies on the shared 32x32 multiplier, then reads the operand
// and executes. Multiply takes one more pass on the multiplier, a bad index
// answers from the check without reading the operand, a negative word skips the
// split, and divide runs a one-bit-per-cycle shift/subtract loop and so sets the
// worst case. A response register holds the finished beat, so the next command
// is taken while it waits; a stalled response holds a finished step until the
// register frees. After reset a clearing pass zeroes the word store, one word
// per cycle, before req_stall drops.
module decimal_accumulator_cpu_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dacs_pkg::cmd_type             req_cmd,
   input  logic [9:0]                    req_load_address,
   input  logic signed [31:0]            req_load_word,
   input  logic signed [31:0]            req_read_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dacs_pkg::status_type          rsp_status,
   output logic [9:0]                    rsp_next_pc,
   output logic [5:0]                    rsp_flags,
   output logic                          rsp_display_valid,
   output logic signed [31:0]            rsp_display_value,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [9:0]                    csr_data
);
   import dacs_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_FWAIT, S_DOP, S_DRD, S_DAD, S_CHECK,
      S_MWAIT, S_EXEC, S_MUL, S_DIV, S_DIVFIN, S_RESP
   } state_type;

   logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
   logic [DATA_WIDTH-1:0] mem_q;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_wa, mem_ra;
   logic [DATA_WIDTH-1:0] mem_wd;

   state_type             state_ff;
   logic [DATA_WIDTH-1:0] regs_ff [NUM_REGS];
   logic [FLAG_W-1:0]     flags_ff;
   logic [ADDR_W-1:0]     pc_ff, start_ff, end_ff, clr_ff;
   logic [DATA_WIDTH-1:0] rem_ff;       // instruction word being split
   logic [Q1_W-1:0]       q1_ff;        // word / 1000
   logic [OPQ_W-1:0]      opq_ff;       // word / 10000
   logic [4:0]            op_ff;
   logic [3:0]            rd_ff;
   logic [ADDR_W-1:0]     ad_ff;
   logic [DATA_WIDTH-1:0] m_ff, r_ff;
   logic [DATA_WIDTH-1:0] q_ff, dr_ff, dd_ff;  // quotient, partial remainder, divisor
   logic [5:0]            cnt_ff;
   logic                  neg_ff;
   logic [31:0]           rdval_ff;
   logic                  rsp_valid_ff, dv_ff;
   status_type            st_ff;
   logic [31:0]           dval_ff;
   status_type            rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_pc_ff;
   logic [FLAG_W-1:0]     rsp_flags_ff;
   logic                  rsp_dv_ff;
   logic [31:0]           rsp_dval_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q <= mem[mem_ra];
   end

   // decode checks from the digit registers
   logic reg_op, mem_op, bad;
   always_comb begin
      reg_op = (op_ff >= 5'd1 && op_ff <= 5'd6) || op_ff == 5'(OP_DIV);
      mem_op = reg_op || op_ff == 5'(OP_RD) || op_ff == 5'(OP_DSP);
      bad = (reg_op && rd_ff >= 4'(NUM_REGS)) || (mem_op && ad_ff >= ADDR_W'(MEM_DEPTH))
            || (op_ff == 5'(OP_BR) && rd_ff >= 4'd6);
   end

   // shared multiplier: digit split reciprocals, then the multiply opcode
   logic [DATA_WIDTH-1:0]   mul_a, mul_b;
   logic [2*DATA_WIDTH-1:0] prod;
   always_comb begin
      unique case (state_ff)
         S_DOP: begin
            mul_a = rem_ff;
            mul_b = DIV1000_MAGIC;
         end
         S_DRD: begin
            mul_a = DATA_WIDTH'(q1_ff);
            mul_b = DIV10_MAGIC;
         end
         default: begin
            mul_a = r_ff;
            mul_b = m_ff;
         end
      endcase
   end
   assign prod = (2*DATA_WIDTH)'(mul_a) * (2*DATA_WIDTH)'(mul_b);

   logic [DATA_WIDTH-1:0] ad_rem;
   logic [Q1_W-1:0]       rd_rem;
   assign ad_rem = rem_ff - DATA_WIDTH'(q1_ff) * DATA_WIDTH'(1000);
   assign rd_rem = q1_ff - Q1_W'(opq_ff) * Q1_W'(10);

   logic [DATA_WIDTH:0] dsub;
   assign dsub = {dr_ff[DATA_WIDTH-1:0], q_ff[DATA_WIDTH-1]} - {1'b0, dd_ff};

   logic lt, eq;
   assign lt = $signed(r_ff) < $signed(m_ff);
   assign eq = r_ff == m_ff;

   logic rsp_load;
   assign rsp_load = state_ff == S_RESP && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff;
      mem_wd = '0;
      mem_ra = pc_ff;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_IDLE && req_valid && req_cmd == CMD_LOAD
                   && req_load_address < ADDR_W'(MEM_DEPTH)) begin
         mem_we = 1'b1;
         mem_wa = req_load_address;
         mem_wd = DATA_WIDTH'(req_load_word);
      end else if (state_ff == S_EXEC && op_ff == 5'(OP_ST)) begin
         mem_we = 1'b1;
         mem_wa = ad_ff;
         mem_wd = r_ff;
      end else if (state_ff == S_EXEC && op_ff == 5'(OP_RD)) begin
         mem_we = 1'b1;
         mem_wa = ad_ff;
         mem_wd = DATA_WIDTH'(rdval_ff);
      end
      if (state_ff == S_CHECK) mem_ra = ad_ff;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_next_pc = rsp_pc_ff;
   assign rsp_flags = rsp_flags_ff;
   assign rsp_display_valid = rsp_dv_ff;
   assign rsp_display_value = rsp_dval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
         flags_ff <= '0;
         pc_ff <= '0;
         start_ff <= '0;
         end_ff <= '0;
         rsp_valid_ff <= 1'b0;
         st_ff <= ST_OK;
         dv_ff <= 1'b0;
         dval_ff <= '0;
         rsp_status_ff <= ST_OK;
         rsp_pc_ff <= '0;
         rsp_flags_ff <= '0;
         rsp_dv_ff <= 1'b0;
         rsp_dval_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index) end_ff <= csr_data;
            else start_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_status_ff <= st_ff;
            rsp_pc_ff <= pc_ff;
            rsp_flags_ff <= flags_ff;
            rsp_dv_ff <= dv_ff;
            rsp_dval_ff <= dval_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  st_ff <= ST_OK;
                  dv_ff <= 1'b0;
                  dval_ff <= '0;
                  rdval_ff <= req_read_value;
                  if (req_cmd == CMD_STEP) begin
                     if (pc_ff > end_ff || pc_ff >= ADDR_W'(MEM_DEPTH)) begin
                        st_ff <= ST_DONE;
                        state_ff <= S_RESP;
                     end else begin
                        state_ff <= S_FETCH;
                     end
                  end else begin
                     if (req_cmd == CMD_RESTART) pc_ff <= start_ff;
                     state_ff <= S_RESP;
                  end
               end
            end
            S_FETCH: state_ff <= S_FWAIT;
            S_FWAIT: begin
               rem_ff <= mem_q;
               op_ff <= '0;
               rd_ff <= '0;
               ad_ff <= '0;
               // negative word: no-op
               if (mem_q[DATA_WIDTH-1]) state_ff <= S_CHECK;
               else state_ff <= S_DOP;
            end
            S_DOP: begin
               q1_ff <= prod[DIV1000_SHIFT +: Q1_W];
               state_ff <= S_DRD;
            end
            S_DRD: begin
               opq_ff <= prod[DIV10_SHIFT +: OPQ_W];
               ad_ff <= ad_rem[ADDR_W-1:0];
               state_ff <= S_DAD;
            end
            S_DAD: begin
               // opcodes above 31 saturate; anything above 10 is a no-op anyway
               op_ff <= (opq_ff > OPQ_W'(31)) ? 5'd31 : opq_ff[4:0];
               rd_ff <= rd_rem[3:0];
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               r_ff <= regs_ff[rd_ff[REG_W-1:0]];
               if (bad) begin
                  st_ff <= ST_BADIDX;
                  pc_ff <= pc_ff + 1'b1;
                  state_ff <= S_RESP;
               end else state_ff <= S_MWAIT;
            end
            S_MWAIT: begin
               m_ff <= mem_q;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_RESP;
               pc_ff <= pc_ff + 1'b1;
               unique case (op_ff)
                  5'(OP_ADD): regs_ff[rd_ff[REG_W-1:0]] <= r_ff + m_ff;
                  5'(OP_SUB): regs_ff[rd_ff[REG_W-1:0]] <= r_ff - m_ff;
                  5'(OP_MUL): begin
                     pc_ff <= pc_ff;
                     state_ff <= S_MUL;
                  end
                  5'(OP_LD): regs_ff[rd_ff[REG_W-1:0]] <= m_ff;
                  5'(OP_CMP): flags_ff <= {!eq, !lt, !lt && !eq, eq, lt || eq, lt};
                  5'(OP_BR): if (flags_ff[rd_ff[2:0]]) pc_ff <= ad_ff;
                  5'(OP_DIV): begin
                     if (m_ff == '0) st_ff <= ST_DIVZ;
                     else begin
                        pc_ff <= pc_ff;
                        q_ff <= r_ff[DATA_WIDTH-1] ? -r_ff : r_ff;
                        dd_ff <= m_ff[DATA_WIDTH-1] ? -m_ff : m_ff;
                        dr_ff <= '0;
                        neg_ff <= r_ff[DATA_WIDTH-1] ^ m_ff[DATA_WIDTH-1];
                        cnt_ff <= '0;
                        state_ff <= S_DIV;
                     end
                  end
                  5'(OP_DSP): begin
                     dv_ff <= 1'b1;
                     dval_ff <= m_ff;
                  end
                  default: ;
               endcase
            end
            S_MUL: begin
               regs_ff[rd_ff[REG_W-1:0]] <= prod[DATA_WIDTH-1:0];
               pc_ff <= pc_ff + 1'b1;
               state_ff <= S_RESP;
            end
            S_DIV: begin
               // restoring divide, one quotient bit per cycle
               if (!dsub[DATA_WIDTH]) begin
                  dr_ff <= dsub[DATA_WIDTH-1:0];
                  q_ff <= {q_ff[DATA_WIDTH-2:0], 1'b1};
               end else begin
                  dr_ff <= {dr_ff[DATA_WIDTH-2:0], q_ff[DATA_WIDTH-1]};
                  q_ff <= {q_ff[DATA_WIDTH-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'(DATA_WIDTH - 1)) state_ff <= S_DIVFIN;
            end
            S_DIVFIN: begin
               regs_ff[rd_ff[REG_W-1:0]] <= neg_ff ? -q_ff : q_ff;
               pc_ff <= pc_ff + 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ test/decimal_accumulator_cpu_step_test.sv @@
// Self-checking testbench for the decimal accumulator step machine.
`timescale 1ns / 1ps
module decimal_accumulator_cpu_step_test;
   import dacs_pkg::*;

   localparam int CSR_START = 0;
   localparam int CSR_END   = 1;
   localparam int LIMIT     = 2000000;

   typedef struct {
      cmd_type     cmd;
      logic [9:0]  addr;
      logic [31:0] word;
      logic [31:0] rval;
   } cmd_beat_t;

   typedef struct {
      status_type  status;
      logic [9:0]  pc;
      logic [5:0]  flags;
      logic        dvalid;
      logic [31:0] dvalue;
   } step_out_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   cmd_type req_cmd = CMD_NOP;
   logic [9:0] req_load_address = '0;
   logic signed [31:0] req_load_word = '0;
   logic signed [31:0] req_read_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   status_type rsp_status;
   logic [9:0] rsp_next_pc;
   logic [5:0] rsp_flags;
   logic rsp_display_valid;
   logic signed [31:0] rsp_display_value;
   logic csr_write = 0;
   logic csr_index = 0;
   logic [9:0] csr_data = '0;

   decimal_accumulator_cpu_step dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow machine
   logic [31:0] mem_shadow [MEM_DEPTH];
   logic [31:0] reg_shadow [NUM_REGS];
   logic [5:0]  flag_shadow;
   logic [9:0]  pc_shadow;
   logic [9:0]  start_shadow, end_shadow;

   step_out_t expected_q [$];
   int mismatches = 0;
   int cycles = 0;
   bit hold_off = 0;

   function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
      logic signed [31:0] sa, sb;
      logic [31:0] ma, mb, q;
      sa = a;
      sb = b;
      ma = sa[31] ? -a : a;
      mb = sb[31] ? -b : b;
      q = ma / mb;
      return (sa[31] != sb[31]) ? -q : q;
   endfunction

   function automatic step_out_t machine_step(cmd_beat_t c);
      step_out_t o;
      logic [31:0] w, m, r;
      int op, rd, ad;
      logic [10:0] npc;
      logic lt, eq;
      o = '{ST_OK, 0, 0, 0, 0};
      if (c.cmd == CMD_LOAD) begin
         if (c.addr < MEM_DEPTH) mem_shadow[c.addr] = c.word;
      end else if (c.cmd == CMD_RESTART) begin
         pc_shadow = start_shadow;
      end else if (c.cmd == CMD_STEP) begin
         if (pc_shadow > end_shadow || pc_shadow >= MEM_DEPTH) begin
            o.status = ST_DONE;
         end else begin
            w = mem_shadow[pc_shadow];
            npc = pc_shadow + 1;
            if (!w[31]) begin
               op = w / 10000;
               rd = (w / 1000) % 10;
               ad = w % 1000;
               if ((((op >= OP_ADD && op <= OP_CMP) || op == OP_DIV) && rd >= NUM_REGS)
                   || (op == OP_BR && rd >= 6)) begin
                  o.status = ST_BADIDX;
               end else begin
                  m = mem_shadow[ad];
                  r = (rd < NUM_REGS) ? reg_shadow[rd] : 0;
                  case (op)
                     OP_ADD: reg_shadow[rd] = r + m;
                     OP_SUB: reg_shadow[rd] = r - m;
                     OP_MUL: reg_shadow[rd] = r * m;
                     OP_LD:  reg_shadow[rd] = m;
                     OP_ST:  mem_shadow[ad] = r;
                     OP_CMP: begin
                        lt = $signed(r) < $signed(m);
                        eq = r == m;
                        flag_shadow = {!eq, !lt, !lt && !eq, eq, lt || eq, lt};
                     end
                     OP_BR: if (flag_shadow[rd]) npc = ad;
                     OP_DIV: begin
                        if (m == 0) o.status = ST_DIVZ;
                        else reg_shadow[rd] = quot_trunc(r, m);
                     end
                     OP_RD: mem_shadow[ad] = c.rval;
                     OP_DSP: begin
                        o.dvalid = 1;
                        o.dvalue = m;
                     end
                     default: ;
                  endcase
               end
            end
            pc_shadow = npc[9:0];
         end
      end
      o.pc = pc_shadow;
      o.flags = flag_shadow;
      return o;
   endfunction

   function automatic logic [31:0] instr(int op, int rd, int ad);
      return op * 10000 + rd * 1000 + ad;
   endfunction

   // a zero-length gap keeps valid up for the next beat
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_beat(cmd_beat_t c, bit typed, step_out_t t);
      step_out_t p;
      p = machine_step(c);
      if (typed && p != t)
         $display("directed row disagrees with shadow: cmd %0d", c.cmd);
      expected_q.push_back(typed ? t : p);
      req_valid <= 1;
      req_cmd <= c.cmd;
      req_load_address <= c.addr;
      req_load_word <= c.word;
      req_read_value <= c.rval;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_set(int idx, int val);
      csr_write <= 1;
      csr_index <= (idx == CSR_END);
      csr_data <= val[9:0];
      @(posedge clock);
      csr_write <= 0;
      if (idx == CSR_START) start_shadow = val[9:0];
      else end_shadow = val[9:0];
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // random program: mostly valid instructions within small range
   task automatic random_phase(int n, int span);
      cmd_beat_t c;
      int k, op;
      for (k = 0; k < n; k++) begin
         c.addr = $urandom_range(0, span);
         c.word = $urandom;
         c.rval = $urandom;
         case ($urandom_range(0, 19))
            0: c.cmd = CMD_RESTART;
            1: c.cmd = CMD_NOP;
            2, 3, 4: begin
               c.cmd = CMD_LOAD;
               op = $urandom_range(0, 11);
               if ($urandom_range(0, 3) != 0)
                  c.word = instr(op, $urandom_range(0, ($urandom_range(0, 7) == 0) ? 9 : 3),
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999)
                                                             : $urandom_range(0, span));
               else if ($urandom_range(0, 1)) c.word = $signed($urandom_range(0, 40)) - 20;
               if ($urandom_range(0, 30) == 0) c.addr = $urandom_range(1000, 1023);
            end
            default: c.cmd = CMD_STEP;
         endcase
         send_beat(c, 0, '{ST_OK, 0, 0, 0, 0});
         idle_gap();
      end
      req_valid <= 0;
   endtask

   cmd_beat_t dir_cmd [$];
   bit        dir_typed [$];
   step_out_t dir_out [$];

   task automatic row(cmd_type cmd, int a, logic [31:0] w, logic [31:0] rv,
                      bit typed = 0, step_out_t t = '{ST_OK, 0, 0, 0, 0});
      dir_cmd.push_back('{cmd, a[9:0], w, rv});
      dir_typed.push_back(typed);
      dir_out.push_back(t);
   endtask

   // response checker
   always @(posedge clock) begin
      step_out_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat");
         end else begin
            e = expected_q.pop_front();
            if (e.status != rsp_status || e.pc != rsp_next_pc || e.flags != rsp_flags ||
                e.dvalid != rsp_display_valid || e.dvalue != rsp_display_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp st%0d pc%0d fl%h dv%0d %h got st%0d pc%0d fl%h dv%0d %h",
                           e.status, e.pc, e.flags, e.dvalid, e.dvalue, rsp_status,
                           rsp_next_pc, rsp_flags, rsp_display_valid, rsp_display_value);
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1;
      else if (hold_off) rsp_stall <= 1;
      else if ($urandom_range(0, 3) == 0) rsp_stall <= 1;
      else if ($urandom_range(0, 60) == 0) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(0, 7) == 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int i;
      int r;
      step_out_t z;
      for (i = 0; i < MEM_DEPTH; i++) mem_shadow[i] = 0;
      for (i = 0; i < NUM_REGS; i++) reg_shadow[i] = 0;
      flag_shadow = 0;
      pc_shadow = 0;
      start_shadow = 0;
      end_shadow = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // step right after reset: word 0 is a no-op
      row(CMD_STEP, 0, 0, 0, 1, '{ST_OK, 1, 0, 0, 0});
      row(CMD_STEP, 0, 0, 0, 1, '{ST_DONE, 1, 0, 0, 0});
      row(CMD_NOP, 0, 0, 0, 1, '{ST_OK, 1, 0, 0, 0});
      row(CMD_LOAD, 1023, 32'hFFFF_FFFF, 0, 1, '{ST_OK, 1, 0, 0, 0});
      row(CMD_LOAD, 999, 32'h8000_0000, 0);
      row(CMD_LOAD, 998, 32'h7FFF_FFFF, 0);
      row(CMD_LOAD, 997, 32'hFFFF_FFFF, 0);
      row(CMD_LOAD, 996, 0, 0);
      row(CMD_LOAD, 0, instr(OP_LD, 0, 999), 0);
      row(CMD_LOAD, 1, instr(OP_DIV, 0, 997), 0);
      row(CMD_LOAD, 2, instr(OP_DIV, 1, 996), 0);
      row(CMD_LOAD, 3, instr(OP_ADD, 1, 998), 0);
      row(CMD_LOAD, 4, instr(OP_SUB, 2, 999), 0);
      row(CMD_LOAD, 5, instr(OP_MUL, 1, 997), 0);
      row(CMD_LOAD, 6, instr(OP_ST, 1, 995), 0);
      row(CMD_LOAD, 7, instr(OP_CMP, 1, 998), 0);
      row(CMD_LOAD, 8, instr(OP_BR, 0, 12), 0);
      row(CMD_LOAD, 9, instr(OP_BR, 6, 0), 0);
      row(CMD_LOAD, 10, instr(OP_RD, 0, 994), 0);
      row(CMD_LOAD, 11, instr(OP_DSP, 0, 994), 0);
      row(CMD_LOAD, 12, instr(OP_ADD, 7, 0), 0);
      row(CMD_LOAD, 13, instr(12, 0, 0), 0);
      row(CMD_LOAD, 14, instr(OP_DSP, 0, 995), 0);
      row(CMD_RESTART, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0});
      for (i = 0; i < dir_cmd.size(); i++) begin
         send_beat(dir_cmd[i], dir_typed[i], dir_out[i]);
         idle_gap();
      end
      drain();
      csr_set(CSR_END, 1023);
      csr_set(CSR_START, 0);
      dir_cmd.delete();
      dir_typed.delete();
      dir_out.delete();
      for (i = 0; i < 20; i++) row(CMD_STEP, 0, 0, 32'hA5A5_5A5A);
      row(CMD_RESTART, 0, 0, 0);
      for (i = 0; i < 12; i++) row(CMD_STEP, 0, 0, 32'h5A5A_A5A5);
      for (i = 0; i < dir_cmd.size(); i++) begin
         send_beat(dir_cmd[i], 0, z);
         idle_gap();
      end
      drain();

      // long receiver hold-off while commands keep coming
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         random_phase(20, 31);
      join
      drain();

      for (r = 0; r < 7; r++) begin
         case (r)
            0: begin csr_set(CSR_START, 0); csr_set(CSR_END, 999); end
            1: begin csr_set(CSR_START, 999); csr_set(CSR_END, 0); end
            2: begin csr_set(CSR_START, 990); csr_set(CSR_END, 999); end
            default: begin
               csr_set(CSR_START, $urandom_range(0, 10));
               csr_set(CSR_END, $urandom_range(10, 40));
            end
         endcase
         random_phase(240, (r == 2) ? 999 : 40);
         drain();
      end

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
